// File: design/stl_pkg.sv
// Package for the source token lexer: result kinds, size constants,
// the result record and the character class helpers.
// No dependencies.
`default_nettype none

package stl_pkg;

    // Longest identifier that is kept; extra characters are dropped.
    localparam int MAX_IDENT_LEN = 32;
    localparam int IDENT_W       = 6;
    localparam int POS_W         = 16;
    localparam int VALUE_W       = 32;
    localparam int KIND_W        = 3;

    // Depth of the result queue; it must hold two results per item.
    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = $clog2(Q_DEPTH);

    // Result kinds as they appear on the output.
    typedef enum logic [KIND_W-1:0] {
        K_CHAR    = 3'd0,
        K_IDEND   = 3'd1,
        K_EOL     = 3'd2,
        K_INT     = 3'd3,
        K_SPECIAL = 3'd4,
        K_EOF     = 3'd5,
        K_BAD     = 3'd6
    } t_kind;

    // One result item.
    typedef struct packed {
        t_kind              kind;
        logic [VALUE_W-1:0] value;
        logic [IDENT_W-1:0] ident_length;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   column;
        logic               last;
    } t_result;

    // Space, tab, newline, vertical tab, form feed, carriage return.
    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    // Brackets, arithmetic operators, '=', both quotes, '<', '>' and '%'.
    function automatic logic is_special(input logic [7:0] c);
        logic r;
        r = 1'b0;
        unique case (c)
            "(", ")", "{", "}", "[", "]", "+", "-", "*", "/",
            "=", 8'h27, 8'h22, "<", ">", "%": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/stl_if.sv
// Channel interfaces of the source token lexer: the byte input channel
// and the token result channel. Depends on stl_pkg.
`default_nettype none

interface stl_in_if;
    import stl_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_text;

    modport source (output valid, output ch, output end_of_text, input ready);
    modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

interface stl_out_if;
    import stl_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [IDENT_W-1:0] ident_length;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   column;
    logic               last;

    modport source (output valid, output kind, output value, output ident_length,
                    output row, output column, output last, input ready);
    modport sink   (input valid, input kind, input value, input ident_length,
                    input row, input column, input last, output ready);
endinterface

`default_nettype wire

// File: design/source_token_lexer.sv
// Top level of the source token lexer: byte classification, token state
// and a small result queue. Depends on stl_pkg and stl_if.
//
//  Channel   Dir  Payload                                        Handshake
//  i_in      in   ch[7:0], end_of_text                           valid/ready
//  o_out     out  kind[2:0], value[31:0], ident_length[5:0],     valid/ready
//                 row[15:0], column[15:0], last
//
// One byte is taken per cycle while the queue has room; each byte yields zero,
// one or two items, which leave the result queue at one per cycle while o_out
// is ready. A result is registered and reaches o_out behind earlier ones.
// Input is taken whenever the queue has room for two more results, so a
// stalled output only stops input once three or more items are waiting.
// Synchronous active-low reset: idle, row and column one, queue empty.
`default_nettype none

module source_token_lexer (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    stl_in_if.sink     i_in,
    stl_out_if.source  o_out
);
    import stl_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_IDENT = 2'd1,
        MODE_INT   = 2'd2
    } t_mode;

    // Token state.
    t_mode               r_mode,  n_mode;
    logic [VALUE_W-1:0]  r_acc,   n_acc;
    logic [IDENT_W-1:0]  r_ident, n_ident;
    logic [POS_W-1:0]    r_row,   n_row;
    logic [POS_W-1:0]    r_col,   n_col;

    // Result queue.
    t_result             r_mem [Q_DEPTH];
    logic [QPTR_W-1:0]   r_wr, n_wr;
    logic [QPTR_W-1:0]   r_rd, n_rd;
    logic [QPTR_W:0]     r_count, n_count;

    logic                accept;
    logic                pop;
    logic                has_f, has_b;
    t_result             res_f, res_b;
    logic [7:0]          c;
    logic                eot;
    logic                alnum;
    t_mode               mode_m;
    logic [VALUE_W-1:0]  acc_m;
    logic [IDENT_W-1:0]  ident_m;

    assign c      = i_in.ch;
    assign eot    = i_in.end_of_text;
    assign alnum  = is_alpha(c) || is_digit(c);

    assign i_in.ready = (r_count <= (QPTR_W+1)'(Q_DEPTH - 2));
    assign accept     = i_in.valid && i_in.ready;
    assign pop        = o_out.valid && o_out.ready;

    // Classify the byte and work out the flushed token and the byte's own result.
    always_comb begin
        has_f   = 1'b0;
        has_b   = 1'b0;
        res_f   = '0;
        res_b   = '0;
        mode_m  = r_mode;
        acc_m   = r_acc;
        ident_m = r_ident;
        n_row   = r_row;
        n_col   = r_col;

        // A pending token that this byte does not continue goes out first,
        // at the position before the byte.
        res_f.row    = r_row;
        res_f.column = r_col;
        if (r_mode == MODE_IDENT && (eot || !alnum)) begin
            has_f              = 1'b1;
            res_f.kind         = K_IDEND;
            res_f.ident_length = r_ident;
            mode_m             = MODE_IDLE;
            ident_m            = '0;
        end else if (r_mode == MODE_INT && (eot || !is_digit(c))) begin
            has_f       = 1'b1;
            res_f.kind  = K_INT;
            res_f.value = r_acc;
            mode_m      = MODE_IDLE;
            acc_m       = '0;
        end else if (r_mode != MODE_IDENT && r_mode != MODE_INT) begin
            mode_m = MODE_IDLE;
        end

        n_mode  = mode_m;
        n_acc   = acc_m;
        n_ident = ident_m;

        if (eot) begin
            // End of text: report end-of-file, position is kept.
            has_b   = 1'b1;
            res_b.kind   = K_EOF;
            res_b.row    = r_row;
            res_b.column = r_col;
            n_mode  = MODE_IDLE;
            n_acc   = '0;
            n_ident = '0;
        end else begin
            // Advance the position, saturating at the top.
            if (c == 8'd10) begin
                n_row = (r_row == '1) ? r_row : r_row + 1'b1;
                n_col = '0;
            end else begin
                n_col = (r_col == '1) ? r_col : r_col + 1'b1;
            end
            res_b.row    = n_row;
            res_b.column = n_col;
            res_b.value  = {{(VALUE_W-8){1'b0}}, c};

            if (is_space(c)) begin
                has_b = 1'b0;
            end else if (mode_m == MODE_IDENT) begin
                if (ident_m < IDENT_W'(MAX_IDENT_LEN)) begin
                    n_ident            = ident_m + 1'b1;
                    has_b              = 1'b1;
                    res_b.kind         = K_CHAR;
                    res_b.ident_length = n_ident;
                end
            end else if (mode_m == MODE_INT) begin
                // Multiply by ten as two shifts and add the digit.
                n_acc = {acc_m[VALUE_W-4:0], 3'b000} + {acc_m[VALUE_W-2:0], 1'b0}
                      + {{(VALUE_W-4){1'b0}}, c[3:0]};
            end else if (is_alpha(c)) begin
                n_mode             = MODE_IDENT;
                n_ident            = IDENT_W'(1);
                has_b              = 1'b1;
                res_b.kind         = K_CHAR;
                res_b.ident_length = IDENT_W'(1);
            end else if (is_digit(c)) begin
                n_mode = MODE_INT;
                n_acc  = {{(VALUE_W-4){1'b0}}, c[3:0]};
            end else if (c == 8'd59) begin
                has_b      = 1'b1;
                res_b.kind = K_EOL;
            end else if (is_special(c)) begin
                has_b      = 1'b1;
                res_b.kind = K_SPECIAL;
            end else begin
                has_b      = 1'b1;
                res_b.kind = K_BAD;
            end
        end

        res_f.last = !has_b;
        res_b.last = 1'b1;
    end

    // Queue pointer and fill count updates.
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (accept) begin
            n_wr    = r_wr + QPTR_W'(has_f) + QPTR_W'(has_b);
            n_count = n_count + (QPTR_W+1)'(has_f) + (QPTR_W+1)'(has_b);
        end
        if (pop) begin
            n_rd    = r_rd + 1'b1;
            n_count = n_count - 1'b1;
        end
    end

    // Token state and queue control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_acc   <= '0;
            r_ident <= '0;
            r_row   <= POS_W'(1);
            r_col   <= POS_W'(1);
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (accept) begin
                r_mode  <= n_mode;
                r_acc   <= n_acc;
                r_ident <= n_ident;
                r_row   <= n_row;
                r_col   <= n_col;
            end
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Result storage: the flushed token first, then the byte's own result.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (has_f) begin
                r_mem[r_wr] <= res_f;
                if (has_b) begin
                    r_mem[r_wr + 1'b1] <= res_b;
                end
            end else if (has_b) begin
                r_mem[r_wr] <= res_b;
            end
        end
    end

    // Head of the queue drives the output.
    assign o_out.valid        = (r_count != '0);
    assign o_out.kind         = r_mem[r_rd].kind;
    assign o_out.value        = r_mem[r_rd].value;
    assign o_out.ident_length = r_mem[r_rd].ident_length;
    assign o_out.row          = r_mem[r_rd].row;
    assign o_out.column       = r_mem[r_rd].column;
    assign o_out.last         = r_mem[r_rd].last;

endmodule

`default_nettype wire

// File: design/stl_checker.sv
// Port checker for the source token lexer and its bind statement.
// Depends on stl_pkg, stl_if and source_token_lexer.
`default_nettype none

module stl_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [stl_pkg::KIND_W-1:0]  i_kind,
    input wire logic [stl_pkg::VALUE_W-1:0] i_value,
    input wire logic [stl_pkg::IDENT_W-1:0] i_ident_length,
    input wire logic                        i_last
);
    import stl_pkg::*;

    // A stalled item stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output item withdrawn while stalled");

    // A stalled item keeps its kind, value, identifier length and last flag.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_kind) && $stable(i_value) && $stable(i_ident_length)
            && $stable(i_last))
        else $error("output payload changed while stalled");

    // Only identifier items carry a length.
    a_len_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_ident_length != '0 |->
            i_kind == K_CHAR || i_kind == K_IDEND)
        else $error("length on a non-identifier item");

    // Identifier length never passes its limit.
    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_ident_length <= IDENT_W'(MAX_IDENT_LEN))
        else $error("identifier length over the limit");

    // End-of-file is always the final item of its input.
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == K_EOF |-> i_last)
        else $error("end-of-file item not marked last");

endmodule

bind source_token_lexer stl_checker u_stl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_kind         (o_out.kind),
    .i_value        (o_out.value),
    .i_ident_length (o_out.ident_length),
    .i_last         (o_out.last)
);

`default_nettype wire
